// ----- design/uenc_pkg.sv -----
// Shared types, constants and helper functions of the URI percent-encoder.
`timescale 1ns / 1ps
`default_nettype none
package uenc_pkg;

    localparam int LOOKAHEAD_DEPTH = 12;
    localparam int WORK_SIZE       = LOOKAHEAD_DEPTH + 2;
    localparam int WIDX_W          = $clog2(WORK_SIZE + 1);
    localparam int MAX_RESULTS     = 24;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int CLASS_SIZE      = 128;

    localparam logic [1:0] REG_CLASS_LOW  = 2'd0;
    localparam logic [1:0] REG_CLASS_HIGH = 2'd1;
    localparam logic [1:0] REG_ESC_MODE   = 2'd2;
    localparam logic [1:0] REG_CHAR_SET   = 2'd3;

    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_KEEP   = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;

    localparam logic [1:0] CS_UTF8   = 2'd0;
    localparam logic [1:0] CS_ASCII  = 2'd1;
    localparam logic [1:0] CS_LATIN1 = 2'd2;

    localparam logic [15:0] CH_PERCENT = 16'h0025;

    typedef struct packed {
        logic load;
        logic take;
        logic gen;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic item_last;
        logic gen_ok;
        logic hold_v;
        logic out_free;
    } t_stat;

    // Returns {valid, weight} of a hex digit of either case.
    function automatic logic [4:0] hex_weight(input logic [15:0] u);
        logic [4:0] r;
        r = 5'd0;
        if (u >= 16'h0030 && u <= 16'h0039) begin
            r = {1'b1, u[3:0]};
        end else if ((u >= 16'h0041 && u <= 16'h0046) ||
                     (u >= 16'h0061 && u <= 16'h0066)) begin
            r = {1'b1, u[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10) begin
            r = 7'h30 + {3'd0, d};
        end else begin
            r = 7'h37 + {3'd0, d};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/uri_percent_encoder.sv -----
// Top level of the URI percent-encoder.
//
// Input channel: i_in_valid / o_in_stall carry one UTF-16 code unit (i_code_unit)
// and the end-of-text mark (i_text_end). Output channel: o_out_valid /
// i_out_stall carry one ASCII character with o_run_last (last character caused
// by one input word), o_stream_end (last character of the text) and
// o_range_error. A word moves at a clock edge where valid is high and stall low.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data), to be
// written only while the block is idle; the block itself does not enforce this.
// Sequence: an input word is loaded, then each decided item takes a decision step
// followed by one step per generated character (1, 3, 6, 9 or 12); a final
// decision that finds nothing left to decide and a flush step end the word.
// A word is accepted only after the previous one has finished.
// The character generator, one character per cycle while the receiver does not
// stall, sets the rate.
// A stalled receiver holds the output register and the generator waits.
// Synchronous reset clears all pending units, the held surrogate and the
// configuration to its defaults (keep escapes, UTF-8, empty class).
`timescale 1ns / 1ps
`default_nettype none
module uri_percent_encoder
    import uenc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [15:0] i_code_unit,
    input  wire         i_text_end,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [6:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic        o_range_error,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    uenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    uenc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_code_unit   (i_code_unit),
        .i_text_end    (i_text_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_char    (o_out_char),
        .o_run_last    (o_run_last),
        .o_stream_end  (o_stream_end),
        .o_range_error (o_range_error)
    );

endmodule
`default_nettype wire

// ----- design/uenc_ctrl.sv -----
// Sequencing state machine of the URI percent-encoder.
`timescale 1ns / 1ps
`default_nettype none
module uenc_ctrl
    import uenc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;
    localparam logic [1:0] ST_FLUSH  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_stat.done) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.gen_ok) begin
                    o_cmd.gen = 1'b1;
                    if (i_stat.item_last) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_stat.hold_v) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

`ifndef ASSERT_OFF
    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_stat.hold_v)
        else $error("held word left over in idle");
`endif

endmodule
`default_nettype wire

// ----- design/uenc_dp.sv -----
// Datapath of the URI percent-encoder: unit window, decision, octet expansion, output.
`timescale 1ns / 1ps
`default_nettype none
module uenc_dp
    import uenc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  wire  [15:0] i_code_unit,
    input  wire         i_text_end,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output logic [6:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_stream_end,
    output logic        o_range_error
);

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_OCTET = 2'd2;

    logic [63:0] r_class_low;
    logic [63:0] r_class_high;
    logic [1:0]  r_mode;
    logic [1:0]  r_cs;

    logic [15:0]       r_w [WORK_SIZE];
    logic [WIDX_W-1:0] r_n;
    logic              r_fin;

    logic       r_plain;
    logic [6:0] r_char;
    logic       r_err;
    logic [7:0] r_oct [4];
    logic [1:0] r_olast;
    logic [1:0] r_oi;
    logic [1:0] r_di;

    logic [CNT_W-1:0] r_cnt;
    logic             r_hold_v;
    logic [6:0]       r_hold_char;
    logic             r_hold_err;
    logic             r_out_v;

    // Decision on the item at the head of the window.
    logic [4:0]  hw1, hw2;
    logic [4:0]  hwa [1:3];
    logic [4:0]  hwd [1:3];
    logic        fail_j [1:3];
    logic        miss_j [1:3];
    logic [7:0]  oct;
    logic [1:0]  len;
    logic [20:0] val;
    logic [20:0] minv;
    logic        valok, anyfail, anymiss;
    logic        p1, p2;
    logic [3:0]  d_k;
    logic [1:0]  d_kind;
    logic [20:0] d_cp;
    logic        done;

    always_comb begin
        hw1 = hex_weight(r_w[1]);
        hw2 = hex_weight(r_w[2]);
        p1  = r_n > WIDX_W'(1);
        p2  = r_n > WIDX_W'(2);
        oct = {hw1[3:0], hw2[3:0]};
        for (int j = 1; j <= 3; j++) begin
            hwa[j]    = hex_weight(r_w[3*j+1]);
            hwd[j]    = hex_weight(r_w[3*j+2]);
            fail_j[j] = ((r_n > WIDX_W'(3*j)) && (r_w[3*j] != CH_PERCENT)) ||
                        ((r_n > WIDX_W'(3*j+1)) &&
                         !(hwa[j][4] && hwa[j][3:2] == 2'b10)) ||
                        ((r_n > WIDX_W'(3*j+2)) && !hwd[j][4]);
            miss_j[j] = !(r_n > WIDX_W'(3*j+2));
        end
        if (oct >= 8'hC2 && oct <= 8'hDF) begin
            len = 2'd1;
        end else if (oct >= 8'hE0 && oct <= 8'hEF) begin
            len = 2'd2;
        end else if (oct >= 8'hF0 && oct <= 8'hF4) begin
            len = 2'd3;
        end else begin
            len = 2'd0;
        end
        anyfail = fail_j[1] || (len >= 2'd2 && fail_j[2]) || (len == 2'd3 && fail_j[3]);
        anymiss = miss_j[1] || (len >= 2'd2 && miss_j[2]) || (len == 2'd3 && miss_j[3]);
        unique case (len)
            2'd1: begin
                val  = {10'd0, oct[4:0], hwa[1][1:0], hwd[1][3:0]};
                minv = 21'h00080;
            end
            2'd2: begin
                val  = {5'd0, oct[3:0], hwa[1][1:0], hwd[1][3:0],
                        hwa[2][1:0], hwd[2][3:0]};
                minv = 21'h00800;
            end
            2'd3: begin
                val  = {oct[2:0], hwa[1][1:0], hwd[1][3:0], hwa[2][1:0], hwd[2][3:0],
                        hwa[3][1:0], hwd[3][3:0]};
                minv = 21'h10000;
            end
            default: begin
                val  = 21'd0;
                minv = 21'd0;
            end
        endcase
        valok = (val >= minv) && !(val >= 21'h0D800 && val <= 21'h0DFFF) &&
                (val <= 21'h10FFFF);

        d_k    = 4'd1;
        d_kind = KIND_PLAIN;
        d_cp   = {5'd0, r_w[0]};
        if (r_w[0] == CH_PERCENT && r_mode != MODE_IGNORE) begin
            if ((p1 && !hw1[4]) || (p2 && !hw2[4]) || ((!p1 || !p2) && r_fin)) begin
                d_k = 4'd1;
            end else if (!p1 || !p2) begin
                d_k = 4'd0;
            end else begin
                d_k  = 4'd3;
                d_cp = {13'd0, oct};
                if (r_cs == CS_ASCII) begin
                    d_kind = oct[7] ? KIND_OCTET : KIND_CHAR;
                end else if (r_cs == CS_LATIN1 || !oct[7]) begin
                    d_kind = KIND_CHAR;
                end else begin
                    d_kind = KIND_OCTET;
                    if (len != 2'd0 && !anyfail) begin
                        if (anymiss) begin
                            d_k = r_fin ? 4'd3 : 4'd0;
                        end else if (valok) begin
                            d_cp   = val;
                            d_kind = KIND_CHAR;
                            d_k    = 4'd3 + 4'd3 * {2'd0, len};
                        end
                    end
                end
            end
        end else if (r_w[0] >= 16'hD800 && r_w[0] <= 16'hDBFF) begin
            if (p1) begin
                if (r_w[1] >= 16'hDC00 && r_w[1] <= 16'hDFFF) begin
                    d_cp = {1'b0, r_w[0][9:0], r_w[1][9:0]} + 21'h10000;
                    d_k  = 4'd2;
                end
            end else if (!r_fin) begin
                d_k = 4'd0;
            end
        end
        done = (r_n == '0) || (d_k == 4'd0);
    end

    // Expansion of the decided item into a plain character or octet escapes.
    logic [CLASS_SIZE-1:0] cls;
    logic                  e_plain;
    logic                  e_err;
    logic [7:0]            e_oct [4];
    logic [1:0]            e_olast;

    always_comb begin
        cls     = {r_class_high, r_class_low};
        e_plain = (d_cp < 21'd128) && cls[d_cp[6:0]] &&
                  (d_kind == KIND_PLAIN || r_mode == MODE_CHECK);
        e_err   = 1'b0;
        e_olast = 2'd0;
        for (int i = 0; i < 4; i++) begin
            e_oct[i] = 8'd0;
        end
        if (d_kind == KIND_OCTET) begin
            e_oct[0] = d_cp[7:0];
        end else if (r_cs == CS_ASCII || r_cs == CS_LATIN1) begin
            e_oct[0] = d_cp[7:0];
            e_err    = (r_cs == CS_ASCII) ? (d_cp > 21'h7F) : (d_cp > 21'hFF);
        end else if (d_cp < 21'h80) begin
            e_oct[0] = d_cp[7:0];
        end else if (d_cp < 21'h800) begin
            e_olast  = 2'd1;
            e_oct[0] = {3'b110, d_cp[10:6]};
            e_oct[1] = {2'b10, d_cp[5:0]};
        end else if (d_cp < 21'h10000) begin
            e_olast  = 2'd2;
            e_oct[0] = {4'b1110, d_cp[15:12]};
            e_oct[1] = {2'b10, d_cp[11:6]};
            e_oct[2] = {2'b10, d_cp[5:0]};
        end else begin
            e_olast  = 2'd3;
            e_oct[0] = {5'b11110, d_cp[20:18]};
            e_oct[1] = {2'b10, d_cp[17:12]};
            e_oct[2] = {2'b10, d_cp[11:6]};
            e_oct[3] = {2'b10, d_cp[5:0]};
        end
    end

    // Window shift after an item is consumed.
    logic [15:0] n_w [WORK_SIZE];

    always_comb begin
        for (int i = 0; i < WORK_SIZE; i++) begin
            unique case (d_k)
                4'd1:  n_w[i] = r_w[(i + 1)  < WORK_SIZE ? i + 1  : i];
                4'd2:  n_w[i] = r_w[(i + 2)  < WORK_SIZE ? i + 2  : i];
                4'd3:  n_w[i] = r_w[(i + 3)  < WORK_SIZE ? i + 3  : i];
                4'd6:  n_w[i] = r_w[(i + 6)  < WORK_SIZE ? i + 6  : i];
                4'd9:  n_w[i] = r_w[(i + 9)  < WORK_SIZE ? i + 9  : i];
                4'd12: n_w[i] = r_w[(i + 12) < WORK_SIZE ? i + 12 : i];
                default: n_w[i] = r_w[i];
            endcase
        end
    end

    // Character generation.
    logic [7:0] cur_oct;
    logic [6:0] g_char;
    logic       item_last;
    logic       drop;
    logic       out_free;
    logic       push_gen;

    always_comb begin
        cur_oct = r_oct[r_oi];
        if (r_plain) begin
            g_char = r_char;
        end else if (r_di == 2'd0) begin
            g_char = CH_PERCENT[6:0];
        end else if (r_di == 2'd1) begin
            g_char = hex_char(cur_oct[7:4]);
        end else begin
            g_char = hex_char(cur_oct[3:0]);
        end
        item_last = r_plain || (r_di == 2'd2 && r_oi == r_olast);
        drop      = r_cnt >= CNT_W'(MAX_RESULTS);
        out_free  = !r_out_v || !i_out_stall;
        push_gen  = i_cmd.gen && !drop && r_hold_v;
    end

    assign o_stat.done      = done;
    assign o_stat.item_last = item_last;
    assign o_stat.gen_ok    = drop || !r_hold_v || out_free;
    assign o_stat.hold_v    = r_hold_v;
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_low  <= 64'd0;
            r_class_high <= 64'd0;
            r_mode       <= MODE_KEEP;
            r_cs         <= CS_UTF8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CLASS_LOW:  r_class_low  <= i_cfg_data;
                REG_CLASS_HIGH: r_class_high <= i_cfg_data;
                REG_ESC_MODE:   r_mode       <= i_cfg_data[1:0];
                REG_CHAR_SET:   r_cs         <= i_cfg_data[1:0];
                default:        r_mode       <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < WORK_SIZE; i++) begin
                if (r_n == WIDX_W'(i)) begin
                    r_w[i] <= i_code_unit;
                end
            end
            r_fin <= i_text_end;
        end else if (i_cmd.take) begin
            r_w <= n_w;
        end
        if (i_cmd.take) begin
            r_plain <= e_plain;
            r_char  <= d_cp[6:0];
            r_err   <= e_err;
            r_oct   <= e_oct;
            r_olast <= e_olast;
        end
        if (i_cmd.gen && !drop) begin
            r_hold_char <= g_char;
            r_hold_err  <= r_plain ? 1'b0 : r_err;
        end
        if (push_gen || i_cmd.flush) begin
            o_out_char    <= r_hold_char;
            o_range_error <= r_hold_err;
            o_run_last    <= i_cmd.flush;
            o_stream_end  <= i_cmd.flush && r_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_oi     <= 2'd0;
            r_di     <= 2'd0;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_n   <= r_n + WIDX_W'(1);
                r_cnt <= '0;
            end else if (i_cmd.take) begin
                r_n <= r_n - WIDX_W'(d_k);
            end
            if (i_cmd.take) begin
                r_oi <= 2'd0;
                r_di <= 2'd0;
            end else if (i_cmd.gen) begin
                if (r_di == 2'd2) begin
                    r_di <= 2'd0;
                    r_oi <= r_oi + 2'd1;
                end else begin
                    r_di <= r_di + 2'd1;
                end
            end
            if (i_cmd.gen && !drop) begin
                r_hold_v <= 1'b1;
                r_cnt    <= r_cnt + CNT_W'(1);
            end else if (i_cmd.flush) begin
                r_hold_v <= 1'b0;
            end
            if (push_gen || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;

`ifndef ASSERT_OFF
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= WIDX_W'(LOOKAHEAD_DEPTH + 1))
        else $error("unit window overflow");
    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_hold_v)
        else $error("held word not released by flush");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");
`endif

endmodule
`default_nettype wire
